@@ hdl/vfs_pkg.sv @@
// shared types and constants for the vertex face shading block
package vfs_pkg;

    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int FACTOR_FRAC_BITS_DEF = 16;

    // shade weights in millionths
    localparam longint unsigned MICRO      = 64'd1000000;
    localparam longint unsigned W_X_MICRO  = 64'd670820;
    localparam longint unsigned W_YB_MICRO = 64'd447213;
    localparam longint unsigned W_YT_MICRO = 64'd1000000;
    localparam longint unsigned W_Z_MICRO  = 64'd836660;

    // side test threshold: square must exceed unit / 1000
    localparam longint unsigned SIDE_DIV = 64'd1000;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_RED    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GREEN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLUE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd4;

    localparam int ADDR_W = 5;

    localparam logic [7:0] COLOR_RST  = 8'd255;
    localparam logic       ENABLE_RST = 1'b1;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_normal;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_color;

endpackage

@@ hdl/vertex_face_shading.sv @@
// vertex face shading: direction-weighted shading of the base color per normal
// pipeline stages from input item to result: square, weight, sum, channel
// throughput: one item per cycle unless stalled; each stage holds only while the stage after it
// is full and stalled, so bubbles close up behind a stalled result
// reset: synchronous, active low; empties the pipeline, base color to 255, shading on
module vertex_face_shading #(
    parameter int NORMAL_FRAC_BITS = vfs_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int FACTOR_FRAC_BITS = vfs_pkg::FACTOR_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  vfs_pkg::t_normal           i_normal,
    output logic                       o_valid,
    input  logic                       i_stall,
    output vfs_pkg::t_color            o_color,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import vfs_pkg::*;

    localparam int SQ_W  = 31;                    // square of a 16 bit value
    localparam int WW    = FACTOR_FRAC_BITS + 1;  // weight width, 1.0 included
    localparam int PW    = SQ_W + WW;             // weighted square
    localparam int SUM_W = PW + 2;                // three terms
    localparam int RS_W  = SUM_W + 1;             // sum with rounding carry
    localparam int CF_W  = FACTOR_FRAC_BITS + 9;  // clamped factor, up to 2^(F+8)
    localparam int CP_W  = CF_W + 8;              // channel times factor
    localparam int CR_W  = CP_W - FACTOR_FRAC_BITS;

    localparam longint unsigned W_X_L  =
        ((W_X_MICRO << FACTOR_FRAC_BITS) + MICRO / 2) / MICRO;
    localparam longint unsigned W_YB_L =
        ((W_YB_MICRO << FACTOR_FRAC_BITS) + MICRO / 2) / MICRO;
    localparam longint unsigned W_YT_L =
        ((W_YT_MICRO << FACTOR_FRAC_BITS) + MICRO / 2) / MICRO;
    localparam longint unsigned W_Z_L  =
        ((W_Z_MICRO << FACTOR_FRAC_BITS) + MICRO / 2) / MICRO;
    localparam longint unsigned SIDE_LIM_L = (64'd1 << (2 * NORMAL_FRAC_BITS)) / SIDE_DIV;

    localparam logic [WW-1:0]   W_X      = W_X_L[WW-1:0];
    localparam logic [WW-1:0]   W_YB     = W_YB_L[WW-1:0];
    localparam logic [WW-1:0]   W_YT     = W_YT_L[WW-1:0];
    localparam logic [WW-1:0]   W_Z      = W_Z_L[WW-1:0];
    localparam logic [SQ_W-1:0] SIDE_LIM = SIDE_LIM_L[SQ_W-1:0];
    localparam logic [RS_W-1:0] SUM_HALF = RS_W'(1) << (2 * NORMAL_FRAC_BITS - 1);
    localparam logic [CF_W-1:0] CF_MAX   = CF_W'(1) << (FACTOR_FRAC_BITS + 8);
    localparam logic [CP_W-1:0] CH_HALF  = CP_W'(1) << (FACTOR_FRAC_BITS - 1);

    // configuration registers
    logic [7:0] r_red, r_green, r_blue, r_alpha;
    logic       r_enable;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red    <= COLOR_RST;
            r_green  <= COLOR_RST;
            r_blue   <= COLOR_RST;
            r_alpha  <= COLOR_RST;
            r_enable <= ENABLE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RED:    r_red    <= pwdata[7:0];
                REG_GREEN:  r_green  <= pwdata[7:0];
                REG_BLUE:   r_blue   <= pwdata[7:0];
                REG_ALPHA:  r_alpha  <= pwdata[7:0];
                REG_ENABLE: r_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RED:    prdata = {24'd0, r_red};
            REG_GREEN:  prdata = {24'd0, r_green};
            REG_BLUE:   prdata = {24'd0, r_blue};
            REG_ALPHA:  prdata = {24'd0, r_alpha};
            REG_ENABLE: prdata = {31'd0, r_enable};
            default:    prdata = 32'd0;
        endcase
    end

    // stage handshake: a stage loads when it is empty or the next one moves
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4  = !r_v4 || !i_stall;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: squares
    logic signed [31:0] w_sq_x, w_sq_y, w_sq_z;
    logic [SQ_W-1:0]    r_x2, r_y2, r_z2;
    logic               r_s1_down;

    assign w_sq_x = i_normal.normal_x * i_normal.normal_x;
    assign w_sq_y = i_normal.normal_y * i_normal.normal_y;
    assign w_sq_z = i_normal.normal_z * i_normal.normal_z;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_x2      <= w_sq_x[SQ_W-1:0];
            r_y2      <= w_sq_y[SQ_W-1:0];
            r_z2      <= w_sq_z[SQ_W-1:0];
            r_s1_down <= i_normal.normal_y[15];
        end
    end

    // stage 2: weighted squares and the shade decision
    logic [PW-1:0] w_px, w_py, w_pz;
    logic [PW-1:0] r_px, r_py, r_pz;
    logic [WW-1:0] w_wy;
    logic          w_side;
    logic          r_s2_shade;

    assign w_wy   = r_s1_down ? W_YB : W_YT;
    assign w_px   = r_x2 * W_X;
    assign w_py   = r_y2 * w_wy;
    assign w_pz   = r_z2 * W_Z;
    assign w_side = (r_x2 > SIDE_LIM) || (r_z2 > SIDE_LIM);

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_px       <= w_px;
            r_py       <= w_py;
            r_pz       <= w_pz;
            r_s2_shade <= r_enable && (r_s1_down || w_side);
        end
    end

    // stage 3: sum, round to the factor format, clamp where every nonzero channel saturates
    logic [RS_W-1:0] w_rsum, w_fac_full;
    logic            w_fac_sat;
    logic [CF_W-1:0] r_factor;
    logic            r_s3_shade;

    assign w_rsum     = RS_W'(r_px) + RS_W'(r_py) + RS_W'(r_pz) + SUM_HALF;
    assign w_fac_full = w_rsum >> (2 * NORMAL_FRAC_BITS);
    assign w_fac_sat  = |(w_fac_full >> (FACTOR_FRAC_BITS + 8));

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_factor   <= w_fac_sat ? CF_MAX : w_fac_full[CF_W-1:0];
            r_s3_shade <= r_s2_shade;
        end
    end

    // stage 4: channel scaling into the output register
    function automatic logic [7:0] shade_ch(input logic [7:0] c, input logic [CF_W-1:0] f);
        logic [CP_W-1:0] p;
        logic [CR_W-1:0] q;
        p = CP_W'(c) * CP_W'(f) + CH_HALF;
        q = p[CP_W-1:FACTOR_FRAC_BITS];
        return (q > CR_W'(255)) ? 8'd255 : q[7:0];
    endfunction

    t_color r_out;
    assign o_color = r_out;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_out.out_alpha <= r_alpha;
            if (r_s3_shade) begin
                r_out.out_red   <= shade_ch(r_red, r_factor);
                r_out.out_green <= shade_ch(r_green, r_factor);
                r_out.out_blue  <= shade_ch(r_blue, r_factor);
            end else begin
                r_out.out_red   <= r_red;
                r_out.out_green <= r_green;
                r_out.out_blue  <= r_blue;
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
// testbench for vertex_face_shading: directed normals, then random phases checked by a predictor
`timescale 1ns / 100ps

module tb_top;
    import vfs_pkg::*;

    localparam int NFB             = NORMAL_FRAC_BITS_DEF;
    localparam int FFB             = FACTOR_FRAC_BITS_DEF;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 222;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_GUARD     = 2000;
    localparam int CYCLE_LIMIT     = 200000;

    localparam t_color FULL_WHITE = '{COLOR_RST, COLOR_RST, COLOR_RST, COLOR_RST};

    typedef struct packed {
        t_normal nrm;
        logic    typed;
        t_color  want;
    } t_vector;

    localparam int NUM_VEC = 22;

    // rows with typed = 1 carry the color read straight off the shading rules
    t_vector vectors [NUM_VEC] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, FULL_WHITE},
        '{'{16'sd0, 16'sd16384, 16'sd0}, 1'b1, FULL_WHITE},
        '{'{16'sd0, 16'sd32767, 16'sd0}, 1'b1, FULL_WHITE},
        '{'{16'sd518, 16'sd0, 16'sd0}, 1'b1, FULL_WHITE},
        '{'{16'sd0, 16'sd0, -16'sd518}, 1'b1, FULL_WHITE},
        '{'{16'h8000, 16'h8000, 16'h8000}, 1'b1, FULL_WHITE},
        '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b1, FULL_WHITE},
        '{'{-16'sd518, 16'sd12345, 16'sd518}, 1'b1, FULL_WHITE},
        '{'{16'sd519, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd519}, 1'b0, '0},
        '{'{-16'sd519, 16'sd100, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, -16'sd1, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, -16'sd16384, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'h8000, 16'sd0}, 1'b0, '0},
        '{'{16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
        '{'{16'h8000, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b0, '0},
        '{'{16'sd9459, 16'sd9459, 16'sd9459}, 1'b0, '0},
        '{'{-16'sd9459, -16'sd9459, 16'sd9459}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0}
    };

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_normal           i_normal = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_color            o_color;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // register shadow used by the predictor
    logic [7:0] cfg_red    = COLOR_RST;
    logic [7:0] cfg_green  = COLOR_RST;
    logic [7:0] cfg_blue   = COLOR_RST;
    logic [7:0] cfg_alpha  = COLOR_RST;
    logic       cfg_enable = ENABLE_RST;

    t_color color_due [$];
    t_color want_color;
    int     err_count   = 0;
    int     cycle_count = 0;
    bit     tx_idle_on  = 1'b1;
    bit     rx_idle_on  = 1'b1;

    vertex_face_shading u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_normal (i_normal),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_color  (o_color),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        err_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic longint unsigned weight_q(longint unsigned micro);
        return ((micro << FFB) + MICRO / 2) / MICRO;
    endfunction

    function automatic logic [7:0] scale_channel(logic [7:0] c, longint unsigned factor);
        longint unsigned p;
        p = (64'(c) * factor + (64'd1 << (FFB - 1))) >> FFB;
        return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    function automatic t_color shade_color(t_normal n);
        longint          sx, sy, sz;
        longint unsigned x2, y2, z2, wy, sum, factor, unit2;
        logic            down, side;
        t_color          res;
        sx    = $signed(n.normal_x);
        sy    = $signed(n.normal_y);
        sz    = $signed(n.normal_z);
        x2    = sx * sx;
        y2    = sy * sy;
        z2    = sz * sz;
        down  = n.normal_y[15];
        unit2 = 64'd1 << (2 * NFB);
        side  = (x2 * SIDE_DIV > unit2) || (z2 * SIDE_DIV > unit2);
        res   = '{cfg_red, cfg_green, cfg_blue, cfg_alpha};
        // near-vertical upward normals, and all normals while shading is off, keep the base color
        if (cfg_enable && (down || side)) begin
            wy     = down ? weight_q(W_YB_MICRO) : weight_q(W_YT_MICRO);
            sum    = weight_q(W_X_MICRO) * x2 + wy * y2 + weight_q(W_Z_MICRO) * z2;
            factor = (sum + (64'd1 << (2 * NFB - 1))) >> (2 * NFB);
            res.out_red   = scale_channel(cfg_red, factor);
            res.out_green = scale_channel(cfg_green, factor);
            res.out_blue  = scale_channel(cfg_blue, factor);
        end
        return res;
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic t_normal rand_normal();
        t_normal n;
        int      a, b, c;
        a = $urandom_range(32768) - 16384;
        b = $urandom_range(1200) - 600;
        c = $urandom_range(1200) - 600;
        case ($urandom_range(9))
            0, 1: n = '{16'($urandom), 16'($urandom), 16'($urandom)};
            2, 3: n = '{16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                        16'($urandom_range(32768) - 16384)};
            4: n = '{16'(a), 16'(b), 16'(c)};
            5: begin
                if ($urandom_range(1) != 0) n = '{16'(b), 16'(a), 16'(c)};
                else n = '{16'(b), 16'(c), 16'(a)};
            end
            // around the side threshold
            6: n = '{16'($urandom_range(1100) - 550), 16'($urandom_range(1100) - 550),
                     16'($urandom_range(1100) - 550)};
            // upward with negligible side parts
            7: n = '{16'($urandom_range(1036) - 518), 16'($urandom_range(32767)),
                     16'($urandom_range(1036) - 518)};
            8: n = '{16'(b), 16'(-int'($urandom_range(32768))), 16'(c)};
            default: n = '{corner_value(), corner_value(), corner_value()};
        endcase
        return n;
    endfunction

    task automatic send_normal(t_normal n, t_color want);
        while (tx_idle_on && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_normal <= n;
        do @(posedge i_clk); while (o_stall);
        color_due.push_back(want);
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [7:0] value);
        logic [31:0] word;
        word = $urandom();
        if (idx == REG_ENABLE) begin
            word[0] = value[0];
        end else begin
            word[7:0] = value;
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the low bits of a field are kept; unknown indexes change nothing
        case (idx)
            REG_RED:    cfg_red    = word[7:0];
            REG_GREEN:  cfg_green  = word[7:0];
            REG_BLUE:   cfg_blue   = word[7:0];
            REG_ALPHA:  cfg_alpha  = word[7:0];
            REG_ENABLE: cfg_enable = word[0];
            default: ;
        endcase
    endtask

    task automatic set_shading(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                               logic en);
        reg_write(REG_RED, r);
        reg_write(REG_GREEN, g);
        reg_write(REG_BLUE, b);
        reg_write(REG_ALPHA, a);
        reg_write(REG_ENABLE, {7'd0, en});
        reg_write(REG_ENABLE + 3'($urandom_range(1, 3)), 8'($urandom));
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (color_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (color_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", color_due.size()));
            color_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (color_due.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want_color = color_due.pop_front();
                check_field("out_red", o_color.out_red, want_color.out_red);
                check_field("out_green", o_color.out_green, want_color.out_green);
                check_field("out_blue", o_color.out_blue, want_color.out_blue);
                check_field("out_alpha", o_color.out_alpha, want_color.out_alpha);
            end
        end
        i_stall <= rx_idle_on && ($urandom_range(99) < 38);
    end

    initial begin
        t_normal n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vectors[k]) begin
            send_normal(vectors[k].nrm,
                        vectors[k].typed ? vectors[k].want : shade_color(vectors[k].nrm));
        end
        i_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: set_shading(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
                1: set_shading(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
                2, 4: set_shading(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                3: set_shading(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                default: set_shading(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
            endcase
            // one phase runs with both sides streaming back to back
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            repeat (ITEMS_PER_PHASE) begin
                n = rand_normal();
                send_normal(n, shade_color(n));
            end
            i_valid <= 1'b0;
        end

        wait_idle();
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
